// File: rtl/core/chs_pkg.sv
// Shared types and constants of the two-histogram chi-square block.
// No dependencies; imported by the top level.
package chs_pkg;

   // Result field widths
   localparam int CHI_W  = 48;
   localparam int USED_W = 11;

   // Sequencer states
   typedef enum logic [3:0] {
      S_LOAD,
      S_SSGO,
      S_SSW,
      S_RD,
      S_CHK,
      S_PQ,
      S_SQ,
      S_DIV,
      S_NEXT,
      S_OUT
   } state_type;

endpackage

// File: rtl/core/chs_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Standalone; used by the chi-square top level.
module chs_serial_mul #(
   parameter int AW = 8,
   parameter int BW = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             done,
   output logic [AW+BW-1:0] product
);

   localparam int CW = $clog2(BW + 1);

   logic [AW-1:0]    a_ff;
   logic [AW+BW-1:0] prod_ff, prod_in;
   logic [AW:0]      sum;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff;

   // Add multiplicand into the high half when the low bit is set, then shift right
   always_comb begin
      sum     = {1'b0, prod_ff[AW+BW-1:BW]} + (prod_ff[0] ? {1'b0, a_ff} : {(AW+1){1'b0}});
      prod_in = {sum, prod_ff[BW-1:1]};
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(BW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff    <= a;
         prod_ff <= {{AW{1'b0}}, b};
      end else if (busy_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// File: rtl/core/chs_serial_div.sv
// Restoring divider, one quotient bit per cycle, flags quotient overflow.
// Standalone; used by the chi-square top level.
module chs_serial_div #(
   parameter int NW = 132,
   parameter int DW = 93,
   parameter int QW = 48
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic          sat,
   output logic [QW-1:0] quotient
);

   localparam int HW  = NW - QW;
   localparam int CMW = (HW > DW) ? HW : DW;
   localparam int CW  = $clog2(QW + 1);

   logic [DW-1:0] den_ff, rem_ff;
   logic [QW-1:0] quo_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff, sat_ff;
   logic [CMW-1:0] hi;
   logic          too_big;
   logic [DW:0]   trial, diff;
   logic          fits;

   // Quotient overflows its field when the high part already reaches the divisor
   always_comb begin
      hi      = CMW'(num[NW-1:QW]);
      too_big = (hi >= CMW'(den));
   end

   // One restoring step
   always_comb begin
      trial = {rem_ff, quo_ff[QW-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= !too_big;
            done_ff <= too_big;
            cnt_ff  <= CW'(QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= DW'(hi);
         quo_ff <= num[QW-1:0];
         sat_ff <= too_big;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DW-1:0] : trial[DW-1:0];
         quo_ff <= {quo_ff[QW-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign sat      = sat_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/two_histogram_chi_square.sv
// Chi-square statistic of two binned data sets with unequal totals. Bins load at
// one transfer per cycle into two on-chip stores while both totals accumulate.
// The transfer marked last starts the evaluation and stalls the input until the
// result is handed to the output register. Sa*Sb is formed once per set, an
// empty bin (or any bin when a total is zero) is skipped, and every other bin
// runs through the bit-serial multipliers and the one-bit-per-cycle divider.
// Each term (Sb*a - Sa*b)^2 / (Sa*Sb*(a+b)) is truncated to FRAC_BITS fraction
// bits and summed with saturation; a zero total gives zero_total.
module two_histogram_chi_square
   import chs_pkg::*;
#(
   parameter int MAX_BINS   = 1024,
   parameter int COUNT_BITS = 24,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COUNT_BITS-1:0] req_count_a,
   input  logic [COUNT_BITS-1:0] req_count_b,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHI_W-1:0]      rsp_chi_square,
   output logic [USED_W-1:0]     rsp_bins_used,
   output logic                  rsp_zero_total,
   output logic                  rsp_saturated
);

   localparam int BNW = $clog2(MAX_BINS + 1);
   localparam int AW  = $clog2(MAX_BINS);
   localparam int TW  = COUNT_BITS + BNW;
   localparam int PW  = TW + COUNT_BITS;
   localparam int NW  = 2 * PW + FRAC_BITS;
   localparam int DW  = 2 * TW + COUNT_BITS + 1;
   localparam logic [CHI_W-1:0] CHI_MAX = '1;

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] mem_a [MAX_BINS];
   logic [COUNT_BITS-1:0] mem_b [MAX_BINS];
   logic [COUNT_BITS-1:0] rd_a_ff, rd_b_ff;

   logic [TW-1:0]     total_a_ff, total_b_ff;
   logic [BNW-1:0]    bins_ff, idx_ff;
   logic [USED_W-1:0] used_ff;
   logic [CHI_W-1:0]  sum_ff;
   logic              sat_ff;

   logic [CHI_W-1:0]  out_chi_ff;
   logic [USED_W-1:0] out_used_ff;
   logic              out_zero_ff, out_sat_ff, out_valid_ff;

   logic in_xfer, zero_tot, bin_empty, out_free;
   logic ss_start, pq_start, sq_start, div_start;
   logic ss_done, p_done, q_done, sq_done, den_done, div_done, div_sat;
   logic [2*TW-1:0]  ss_prod;
   logic [PW-1:0]    p_prod, q_prod, diff;
   logic [2*PW-1:0]  sq_prod;
   logic [DW-1:0]    den_prod;
   logic [CHI_W-1:0] quo;
   logic [CHI_W:0]   sum_next;
   logic [COUNT_BITS:0] bin_sum;

   assign in_xfer   = req_valid && !req_stall;
   assign zero_tot  = (total_a_ff == '0) || (total_b_ff == '0);
   assign bin_sum   = {1'b0, rd_a_ff} + {1'b0, rd_b_ff};
   assign bin_empty = (bin_sum == '0);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign diff      = (p_prod >= q_prod) ? (p_prod - q_prod) : (q_prod - p_prod);
   assign sum_next  = {1'b0, sum_ff} + {1'b0, quo};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD: if (in_xfer && req_last) state_in = S_SSGO;
         S_SSGO: state_in = S_SSW;
         S_SSW:  if (ss_done) state_in = S_RD;
         S_RD:   state_in = S_CHK;
         S_CHK:  state_in = (bin_empty || zero_tot) ? S_NEXT : S_PQ;
         S_PQ:   if (p_done) state_in = S_SQ;
         S_SQ:   if (sq_done) state_in = S_DIV;
         S_DIV:  if (div_done) state_in = S_NEXT;
         S_NEXT: state_in = (idx_ff + 1'b1 == bins_ff) ? S_OUT : S_RD;
         S_OUT:  if (out_free) state_in = S_LOAD;
         default: state_in = S_LOAD;
      endcase
   end

   // Unit starts and input stall
   always_comb begin
      req_stall = (state_ff != S_LOAD);
      ss_start  = (state_ff == S_SSGO);
      pq_start  = (state_ff == S_CHK) && !bin_empty && !zero_tot;
      sq_start  = (state_ff == S_PQ) && p_done;
      div_start = (state_ff == S_SQ) && sq_done;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_LOAD;
      else       state_ff <= state_in;
   end

   // Bin stores: write on load, registered read during the scan
   always_ff @(posedge clock) begin
      if (in_xfer && (bins_ff < BNW'(MAX_BINS))) begin
         mem_a[bins_ff[AW-1:0]] <= req_count_a;
         mem_b[bins_ff[AW-1:0]] <= req_count_b;
      end
      rd_a_ff <= mem_a[idx_ff[AW-1:0]];
      rd_b_ff <= mem_b[idx_ff[AW-1:0]];
   end

   // Totals, counters and the running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         total_a_ff <= '0;
         total_b_ff <= '0;
         bins_ff    <= '0;
         idx_ff     <= '0;
         used_ff    <= '0;
         sum_ff     <= '0;
         sat_ff     <= 1'b0;
      end else begin
         if (in_xfer && (bins_ff < BNW'(MAX_BINS))) begin
            total_a_ff <= total_a_ff + TW'(req_count_a);
            total_b_ff <= total_b_ff + TW'(req_count_b);
            bins_ff    <= bins_ff + 1'b1;
         end
         if (state_ff == S_CHK && !bin_empty) used_ff <= used_ff + 1'b1;
         if (state_ff == S_NEXT) idx_ff <= idx_ff + 1'b1;
         if (state_ff == S_DIV && div_done) begin
            if (div_sat || sum_next[CHI_W]) begin
               sum_ff <= CHI_MAX;
               sat_ff <= 1'b1;
            end else begin
               sum_ff <= sum_next[CHI_W-1:0];
            end
         end
         if (state_ff == S_OUT && out_free) begin
            total_a_ff <= '0;
            total_b_ff <= '0;
            bins_ff    <= '0;
            idx_ff     <= '0;
            used_ff    <= '0;
            sum_ff     <= '0;
            sat_ff     <= 1'b0;
         end
      end
   end

   // Output register: hold until transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         out_chi_ff  <= zero_tot ? '0 : sum_ff;
         out_sat_ff  <= zero_tot ? 1'b0 : sat_ff;
         out_zero_ff <= zero_tot;
         out_used_ff <= used_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_chi_square = out_chi_ff;
   assign rsp_bins_used  = out_used_ff;
   assign rsp_zero_total = out_zero_ff;
   assign rsp_saturated  = out_sat_ff;

   // Sa*Sb, once per set
   chs_serial_mul #(.AW(TW), .BW(TW)) u_mul_ss (
      .clock(clock), .reset(reset), .start(ss_start),
      .a(total_a_ff), .b(total_b_ff), .done(ss_done), .product(ss_prod)
   );

   // Sb*a and Sa*b
   chs_serial_mul #(.AW(TW), .BW(COUNT_BITS)) u_mul_p (
      .clock(clock), .reset(reset), .start(pq_start),
      .a(total_b_ff), .b(rd_a_ff), .done(p_done), .product(p_prod)
   );

   chs_serial_mul #(.AW(TW), .BW(COUNT_BITS)) u_mul_q (
      .clock(clock), .reset(reset), .start(pq_start),
      .a(total_a_ff), .b(rd_b_ff), .done(q_done), .product(q_prod)
   );

   // Square of the difference and Sa*Sb*(a+b), side by side
   chs_serial_mul #(.AW(PW), .BW(PW)) u_mul_sq (
      .clock(clock), .reset(reset), .start(sq_start),
      .a(diff), .b(diff), .done(sq_done), .product(sq_prod)
   );

   chs_serial_mul #(.AW(2*TW), .BW(COUNT_BITS+1)) u_mul_den (
      .clock(clock), .reset(reset), .start(sq_start),
      .a(ss_prod), .b(bin_sum), .done(den_done), .product(den_prod)
   );

   chs_serial_div #(.NW(NW), .DW(DW), .QW(CHI_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(NW'(sq_prod) << FRAC_BITS), .den(den_prod),
      .done(div_done), .sat(div_sat), .quotient(quo)
   );

   // q and den finish in step with or ahead of their partners
   logic unused_done;
   assign unused_done = q_done ^ den_done;

endmodule
